>>> hdl/peg_pkg.sv
// ----------------------------------------------------------------------------
// Percussive envelope generator package
// Shared widths, constants and register indexes for the envelope generator.
// ----------------------------------------------------------------------------
package peg_pkg;

    localparam int COUNT_WIDTH   = 24;
    localparam int RELEASE_STEPS = 256;

    localparam int LEVEL_W  = 17;
    localparam int OFFSET_W = COUNT_WIDTH + 3;
    localparam int NL_W     = LEVEL_W + 2;
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;

    localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(65536);

    typedef enum logic [2:0] {
        REG_DELAY_LEN   = 3'd0,
        REG_ATTACK_LEN  = 3'd1,
        REG_HOLD_LEN    = 3'd2,
        REG_DECAY_LEN   = 3'd3,
        REG_ATTACK_STEP = 3'd4,
        REG_DECAY_STEP  = 3'd5
    } reg_index_t;

    typedef logic [COUNT_WIDTH-1:0]   count_t;
    typedef logic [LEVEL_W-1:0]       level_t;
    typedef logic signed [OFFSET_W-1:0] offset_t;

endpackage

>>> hdl/percussive_envelope_generator.sv
// ----------------------------------------------------------------------------
// Percussive envelope generator
// Delay-attack-hold-decay envelope, one audio sample per stream item.
// ----------------------------------------------------------------------------
// Each item on the slave stream carries the gate bit in s_tdata[0] and the
// retrigger bit in s_tdata[1]. Each item produces exactly one item on the
// master stream with the envelope level and its negation, both Q1.16.
// An item is registered in an input stage and the envelope update is done
// between that stage and the output register, which drives m_tvalid, and
// one item is taken in every clock cycle while m_tready is high.
// When the receiver holds m_tready low, the output register keeps its item,
// the input stage takes at most one more item, and s_tready then stays low
// until m_tready returns.
// The six registers are written through the APB port at byte addresses
// 0, 4, 8, 12, 16 and 20, and should be changed only while no item is in
// flight. Reset clears the registers, the envelope state and both stages.
// After reset the envelope plays through once, because the phase counter
// starts at zero.
// ----------------------------------------------------------------------------
module percussive_envelope_generator (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [peg_pkg::S_DATA_W-1:0]   s_tdata,   // gate_in, retrig_in
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [peg_pkg::M_DATA_W-1:0]   m_tdata,   // env_out, inv_env_out
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [peg_pkg::ADDR_W-1:0]     paddr,
    input  logic [peg_pkg::DATA_W-1:0]     pwdata,
    output logic [peg_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);
    import peg_pkg::*;

    count_t delay_len_reg, attack_len_reg, hold_len_reg, decay_len_reg;
    level_t attack_step_reg, decay_step_reg;

    logic   in_valid_reg;
    logic   gate_in_reg, retrig_in_reg;
    logic   out_valid_reg;
    level_t env_out_reg, inv_env_out_reg;

    logic    gate_high_reg, retrig_high_reg;
    offset_t phase_offset_reg, phase_offset_next;
    level_t  level_reg, level_next;
    level_t  release_step_reg, release_step_next;

    logic       fire;
    logic       cfg_write;
    reg_index_t cfg_index;

    offset_t b_delay, b_attack, b_hold, b_decay;
    count_t  hold_eff;
    offset_t off_gate, off_trig;
    logic [LEVEL_W+COUNT_WIDTH-1:0] trig_prod;
    logic signed [NL_W-1:0] nl;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_len_reg   <= '0;
            attack_len_reg  <= '0;
            hold_len_reg    <= '0;
            decay_len_reg   <= '0;
            attack_step_reg <= '0;
            decay_step_reg  <= '0;
        end else if (cfg_write) begin
            unique case (cfg_index)
                REG_DELAY_LEN:   delay_len_reg   <= pwdata[COUNT_WIDTH-1:0];
                REG_ATTACK_LEN:  attack_len_reg  <= pwdata[COUNT_WIDTH-1:0];
                REG_HOLD_LEN:    hold_len_reg    <= pwdata[COUNT_WIDTH-1:0];
                REG_DECAY_LEN:   decay_len_reg   <= pwdata[COUNT_WIDTH-1:0];
                REG_ATTACK_STEP: attack_step_reg <= pwdata[LEVEL_W-1:0];
                REG_DECAY_STEP:  decay_step_reg  <= pwdata[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_index)
            REG_DELAY_LEN:   prdata = DATA_W'(delay_len_reg);
            REG_ATTACK_LEN:  prdata = DATA_W'(attack_len_reg);
            REG_HOLD_LEN:    prdata = DATA_W'(hold_len_reg);
            REG_DECAY_LEN:   prdata = DATA_W'(decay_len_reg);
            REG_ATTACK_STEP: prdata = DATA_W'(attack_step_reg);
            REG_DECAY_STEP:  prdata = DATA_W'(decay_step_reg);
            default:         prdata = '0;
        endcase
    end

    assign fire     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            gate_in_reg   <= s_tdata[0];
            retrig_in_reg <= s_tdata[1];
        end
    end

    assign hold_eff = (hold_len_reg == '0) ? COUNT_WIDTH'(1) : hold_len_reg;
    assign b_delay  = OFFSET_W'(delay_len_reg);
    assign b_attack = b_delay + OFFSET_W'(attack_len_reg);
    assign b_hold   = b_attack + OFFSET_W'(hold_eff);
    assign b_decay  = b_hold + OFFSET_W'(decay_len_reg);

    assign trig_prod = LEVEL_W'(level_reg) * attack_len_reg;

    always_comb begin
        off_gate          = phase_offset_reg;
        release_step_next = release_step_reg;
        if (gate_in_reg && !gate_high_reg) begin
            if (level_reg != '0) begin
                off_gate          = -OFFSET_W'(RELEASE_STEPS);
                release_step_next = LEVEL_W'(level_reg / RELEASE_STEPS);
            end else begin
                off_gate = '0;
            end
        end

        off_trig = off_gate;
        if (retrig_in_reg && !retrig_high_reg) begin
            if (level_reg != '0 && attack_len_reg != '0) begin
                off_trig = OFFSET_W'(trig_prod[16 +: COUNT_WIDTH]);
            end else begin
                off_trig = '0;
            end
        end

        nl = NL_W'(level_reg);
        if (off_trig < 0) begin
            nl = nl - NL_W'(release_step_next);
        end else if (off_trig < b_delay) begin
            nl = '0;
        end else if (off_trig < b_attack) begin
            nl = nl + NL_W'(attack_step_reg);
        end else if (off_trig < b_hold) begin
            nl = NL_W'(LEVEL_ONE);
        end else if (off_trig < b_decay) begin
            nl = nl - NL_W'(decay_step_reg);
        end else begin
            nl = '0;
        end

        if (nl < 0) begin
            level_next = '0;
        end else if (nl > NL_W'(LEVEL_ONE)) begin
            level_next = LEVEL_ONE;
        end else begin
            level_next = nl[LEVEL_W-1:0];
        end

        if (off_trig < b_decay) begin
            phase_offset_next = off_trig + OFFSET_W'(1);
        end else begin
            phase_offset_next = b_decay;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gate_high_reg    <= 1'b0;
            retrig_high_reg  <= 1'b0;
            phase_offset_reg <= '0;
            level_reg        <= '0;
            release_step_reg <= '0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (fire) begin
                gate_high_reg    <= gate_in_reg;
                retrig_high_reg  <= retrig_in_reg;
                phase_offset_reg <= phase_offset_next;
                level_reg        <= level_next;
                release_step_reg <= release_step_next;
                out_valid_reg    <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            env_out_reg     <= level_next;
            inv_env_out_reg <= -level_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 2*LEVEL_W){1'b0}}, inv_env_out_reg, env_out_reg};

endmodule
